[sv/ktse_pkg.sv]
// Package for the key table search engine: widths, codes, request and result types.
// No dependencies.
package ktse_pkg;
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CntW       = AddrW + 1;
  localparam int unsigned CapW       = 11;
  localparam int unsigned StackDepth = 40;
  localparam int unsigned SpW        = $clog2(StackDepth + 1);

  typedef enum logic [2:0] {
    MODE_INSERT = 3'd0,
    MODE_LEVEL  = 3'd1,
    MODE_INORD  = 3'd2,
    MODE_SORT   = 3'd3,
    MODE_BIN    = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]    mode;
    logic [31:0]   key;
  } req_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [9:0]    index;
  } rsp_t;
endpackage

[sv/ktse_if.sv]
// Valid/ready channel interfaces for requests, results and capacity config.
// Depends on ktse_pkg.
interface ktse_req_if;
  logic              valid;
  logic              ready;
  ktse_pkg::req_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ktse_rsp_if;
  logic              valid;
  logic              ready;
  ktse_pkg::rsp_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ktse_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ktse_pkg::CapW-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/key_table_search_engine.sv]
// Top level of the key table search engine: sequencer around one key RAM.
// Depends on ktse_pkg, ktse_if, ktse_ram, ktse_stack.
// One request at a time; every RAM access is one registered read or one
// write on a single port. Insert and modes 5-7 go straight to the result;
// level find is a linear scan, binary search halves the range, in-order
// find walks the tree with a node stack, and sort is a heapsort. The
// result sits in an output register, taken by rsp ready, and a new request
// is taken only after the result has left.
module key_table_search_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  ktse_req_if.sink       req,
  ktse_rsp_if.source     rsp,
  ktse_cfg_if.sink       cfg
);
  localparam int unsigned AW = ktse_pkg::AddrW;
  localparam int unsigned CW = ktse_pkg::CntW;
  localparam int unsigned KW = ktse_pkg::KeyWidth;

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_LVRD  = 18'h00002,
    S_LVCK  = 18'h00004,
    S_BNRD  = 18'h00008,
    S_BNCK  = 18'h00010,
    S_IODN  = 18'h00020,
    S_IOPP  = 18'h00040,
    S_IOCK  = 18'h00080,
    S_SSTEP = 18'h00100,
    S_XA    = 18'h00200,
    S_XB    = 18'h00400,
    S_XC    = 18'h00800,
    S_SDRT  = 18'h01000,
    S_SDL   = 18'h02000,
    S_SDR   = 18'h04000,
    S_SDC   = 18'h08000,
    S_SDW   = 18'h10000,
    S_OUT   = 18'h20000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] fill_q, fill_d, n_q, n_d;
  logic [ktse_pkg::CapW-1:0] cap_q;
  logic [KW-1:0] key_q, key_d;
  logic [CW-1:0] i_q, i_d, lo_q, lo_d, hi_q, hi_d;
  logic [AW:0] cur_q, cur_d;
  logic [CW-1:0] heap_q, heap_d;   // heap size during sort
  logic phase_q, phase_d;         // 0 build, 1 extract
  logic [AW-1:0] root_q, root_d, big_q, big_d;
  logic [KW-1:0] rootv_q, rootv_d, bigv_q, bigv_d;
  ktse_pkg::rsp_t res_q, res_d;
  logic ovalid_q, ovalid_d;

  logic          we;
  logic [AW-1:0] addr;
  logic [KW-1:0] wdata, rdata;

  logic st_clr, st_push, st_pop;
  logic [AW:0] st_top;
  logic [ktse_pkg::SpW-1:0] sp;

  ktse_ram #(.Width(KW), .Depth(ktse_pkg::TableDepth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  ktse_stack u_stack (
    .clk_i, .rst_ni, .clr_i(st_clr), .push_i(st_push), .pop_i(st_pop),
    .data_i(cur_q), .top_o(st_top), .sp_o(sp)
  );

  logic [CW-1:0] eff_cap, eff_fill, mid;
  logic [KW-1:0] kbias;
  logic [AW:0] lchild;
  logic [AW+1:0] rchild;
  logic l_ok, r_ok;
  logic [AW+1:0] cur_l;

  assign eff_cap  = (cap_q > ktse_pkg::CapW'(ktse_pkg::TableDepth))
                    ? CW'(ktse_pkg::TableDepth) : CW'(cap_q);
  assign eff_fill = (fill_q > CW'(ktse_pkg::TableDepth))
                    ? CW'(ktse_pkg::TableDepth) : fill_q;
  assign kbias    = req.payload.key ^ {1'b1, {(KW-1){1'b0}}};
  assign mid      = CW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
  assign lchild   = {root_q, 1'b1};
  assign rchild   = {1'b0, lchild} + 1'b1;
  assign l_ok     = lchild < heap_q;
  assign r_ok     = rchild < {1'b0, heap_q};
  assign cur_l    = {cur_q, 1'b1};

  assign req.ready   = (state_q == S_IDLE) && !ovalid_q;
  assign cfg.ready   = 1'b1;
  assign rsp.valid   = ovalid_q;
  assign rsp.payload = res_q;

  always_comb begin
    state_d = state_q; fill_d = fill_q; n_d = n_q; key_d = key_q;
    i_d = i_q; lo_d = lo_q; hi_d = hi_q; cur_d = cur_q;
    heap_d = heap_q; phase_d = phase_q; root_d = root_q; big_d = big_q;
    rootv_d = rootv_q; bigv_d = bigv_q; res_d = res_q;
    ovalid_d = ovalid_q && !rsp.ready;
    we = 1'b0; addr = '0; wdata = '0;
    st_clr = 1'b0; st_push = 1'b0; st_pop = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          key_d = kbias; n_d = eff_fill;
          res_d = '{status: ktse_pkg::ST_OK, index: '0};
          i_d = '0; lo_d = '0; hi_d = eff_fill; cur_d = '0; st_clr = 1'b1;
          case (req.payload.mode)
            ktse_pkg::MODE_INSERT: begin
              if (fill_q >= eff_cap) begin
                res_d.status = ktse_pkg::ST_FULL;
              end else begin
                we = 1'b1; addr = AW'(fill_q); wdata = kbias;
                res_d.index = AW'(fill_q);
                fill_d = fill_q + 1'b1;
              end
              state_d = S_OUT;
            end
            ktse_pkg::MODE_LEVEL: state_d = S_LVRD;
            ktse_pkg::MODE_INORD: state_d = S_IODN;
            ktse_pkg::MODE_BIN:   state_d = S_BNRD;
            ktse_pkg::MODE_SORT: begin
              heap_d = eff_fill; phase_d = 1'b0;
              i_d = CW'(eff_fill >> 1);
              state_d = (eff_fill < CW'(2)) ? S_OUT : S_SSTEP;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_OUT: begin
        ovalid_d = 1'b1; state_d = S_IDLE;
      end
      S_LVRD: begin
        if (i_q >= n_q) begin
          res_d.status = ktse_pkg::ST_MISSING; state_d = S_OUT;
        end else begin
          addr = AW'(i_q); state_d = S_LVCK;
        end
      end
      S_LVCK: begin
        if (rdata == key_q) begin
          res_d.index = AW'(i_q); state_d = S_OUT;
        end else begin
          i_d = i_q + 1'b1; state_d = S_LVRD;
        end
      end
      S_BNRD: begin
        if (lo_q >= hi_q) begin
          res_d.status = ktse_pkg::ST_MISSING; state_d = S_OUT;
        end else begin
          addr = AW'(mid); i_d = mid; state_d = S_BNCK;
        end
      end
      S_BNCK: begin
        if (rdata == key_q) begin
          res_d.index = AW'(i_q); state_d = S_OUT;
        end else begin
          if (rdata > key_q) hi_d = i_q;
          else lo_d = i_q + 1'b1;
          state_d = S_BNRD;
        end
      end
      S_IODN: begin
        if (CW'(cur_q) < n_q && sp < ktse_pkg::SpW'(ktse_pkg::StackDepth)) begin
          st_push = 1'b1;
          cur_d = (cur_l > (AW+2)'(ktse_pkg::TableDepth))
                  ? (AW+1)'(ktse_pkg::TableDepth) : cur_l[AW:0];
        end else if (sp == '0) begin
          res_d.status = ktse_pkg::ST_MISSING; state_d = S_OUT;
        end else begin
          st_pop = 1'b1; state_d = S_IOPP;
        end
      end
      S_IOPP: begin
        cur_d = st_top; addr = st_top[AW-1:0]; state_d = S_IOCK;
      end
      S_IOCK: begin
        if (rdata == key_q) begin
          res_d.index = cur_q[AW-1:0]; state_d = S_OUT;
        end else begin
          cur_d = ((AW+2)'({cur_q, 1'b0}) + 2 > (AW+2)'(ktse_pkg::TableDepth))
                  ? (AW+1)'(ktse_pkg::TableDepth) : (AW+1)'({cur_q, 1'b0} + 2);
          state_d = S_IODN;
        end
      end
      S_SSTEP: begin
        if (!phase_q) begin
          if (i_q == '0) begin
            phase_d = 1'b1; i_d = heap_q - 1'b1;
          end else begin
            root_d = AW'(i_q - 1'b1); i_d = i_q - 1'b1; state_d = S_SDRT;
          end
        end else if (i_q == '0) begin
          state_d = S_OUT;
        end else begin
          // swap 0 and i, then sift 0 with heap size i
          addr = '0; state_d = S_XA;
        end
      end
      S_XA: begin
        rootv_d = rdata; addr = AW'(i_q); state_d = S_XB;
      end
      S_XB: begin
        we = 1'b1; addr = '0; wdata = rdata; state_d = S_XC;
      end
      S_XC: begin
        we = 1'b1; addr = AW'(i_q); wdata = rootv_q;
        heap_d = i_q; i_d = i_q - 1'b1; root_d = '0;
        state_d = S_SDRT;
      end
      S_SDRT: begin
        addr = root_q; state_d = S_SDL;
      end
      S_SDL: begin
        rootv_d = rdata; bigv_d = rdata; big_d = root_q;
        addr = l_ok ? lchild[AW-1:0] : '0;
        state_d = S_SDR;
      end
      S_SDR: begin
        if (l_ok && rdata > bigv_q) begin
          bigv_d = rdata; big_d = lchild[AW-1:0];
        end
        addr = r_ok ? rchild[AW-1:0] : '0;
        state_d = S_SDC;
      end
      S_SDC: begin
        if (r_ok && rdata > bigv_q) begin
          bigv_d = rdata; big_d = rchild[AW-1:0];
        end
        if (big_d == root_q) begin
          state_d = S_SSTEP;
        end else begin
          we = 1'b1; addr = root_q; wdata = bigv_d; state_d = S_SDW;
        end
      end
      S_SDW: begin
        we = 1'b1; addr = big_q; wdata = rootv_q;
        root_d = big_q; state_d = S_SDRT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; fill_q <= '0; ovalid_q <= 1'b0;
      cap_q <= ktse_pkg::CapW'(1024);
    end else begin
      state_q <= state_d; fill_q <= fill_d; ovalid_q <= ovalid_d;
      if (cfg.valid && cfg.ready) cap_q <= cfg.data;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; key_q <= key_d; i_q <= i_d; lo_q <= lo_d; hi_q <= hi_d;
    cur_q <= cur_d; heap_q <= heap_d; phase_q <= phase_d; root_q <= root_d;
    big_q <= big_d; rootv_q <= rootv_d; bigv_q <= bigv_d; res_q <= res_d;
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> state_q == S_IDLE) else $error("ready outside idle");
  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(ktse_pkg::TableDepth)) else $error("fill overflow");
  a_out_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |=> ovalid_q) else $error("result lost");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> res_q.status != 2'd3) else $error("bad status");
endmodule

[sv/ktse_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module ktse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

[sv/ktse_stack.sv]
// Node stack for the in-order tree walk, kept in one RAM with registered read.
// Depends on ktse_pkg and ktse_ram; a popped node shows on top_o in the cycle after the pop.
module ktse_stack (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clr_i,
  input  logic                        push_i,
  input  logic                        pop_i,
  input  logic [ktse_pkg::AddrW:0]    data_i,
  output logic [ktse_pkg::AddrW:0]    top_o,
  output logic [ktse_pkg::SpW-1:0]    sp_o
);
  logic [ktse_pkg::SpW-1:0]  sp_q, sp_d;
  logic                      we;
  logic [ktse_pkg::SpW-1:0]  addr;

  always_comb begin
    sp_d = sp_q;
    if (clr_i) sp_d = '0;
    else if (push_i) sp_d = sp_q + 1'b1;
    else if (pop_i) sp_d = sp_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sp_q <= '0;
    else sp_q <= sp_d;
  end

  assign we   = push_i && !clr_i;
  assign addr = pop_i ? sp_q - 1'b1 : sp_q;

  ktse_ram #(.Width(ktse_pkg::AddrW + 1), .Depth(ktse_pkg::StackDepth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(data_i), .rdata_o(top_o)
  );

  assign sp_o = sp_q;
endmodule
